// ===== rtl/core/stbs_pkg.sv =====
// Shared types and constants for the sorted table search block.
package stbs_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned CMD_W           = 2;
    localparam int unsigned MATCH_W         = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } t_state;

endpackage

// ===== rtl/core/stbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// Sorted table of signed values with append, clear and binary search commands.
//
// Values are appended in ascending order (not checked) into a single-port-read RAM of
// TABLE_DEPTH words. Append and clear are handled directly from the idle state. A search
// runs a binary search with one shared compare unit under a small sequencer: each probe
// issues the RAM read at the midpoint, then compares the registered read word; a result
// waits in the sequencer until the output register frees up. The input side is ready
// only while no search is in progress; one result is produced per search, none for
// append or clear. match_index carries the low 10 bits of the matching index, zero when
// nothing matched; overflowed reports a dropped append since the last clear.
module sorted_table_binary_search #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [stbs_pkg::CMD_W-1:0]    i_command,
    input  logic signed [stbs_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [stbs_pkg::MATCH_W-1:0]  o_match_index,
    output logic                          o_overflowed
);

    import stbs_pkg::*;

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SRCH_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_drop, n_drop;
    logic signed [VALUE_W-1:0]  r_key, n_key;
    logic signed [SRCH_W-1:0]   r_low, n_low;
    logic signed [SRCH_W-1:0]   r_high, n_high;
    logic signed [SRCH_W-1:0]   r_mid, n_mid;
    logic                       r_out_valid, n_out_valid;
    logic                       r_found, n_found;
    logic [MATCH_W-1:0]         r_match_index, n_match_index;
    logic                       r_overflowed, n_overflowed;

    logic                       in_fire;
    logic                       out_free;
    logic signed [SRCH_W-1:0]   mid_calc;
    logic                       wr_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  probe;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign probe      = $signed(rd_data);
    assign mid_calc   = r_low + ((r_high - r_low) >>> 1);
    assign wr_en      = in_fire && (i_command == CMD_APPEND) && (r_count < DEPTH_CNT);
    assign rd_addr    = (r_state == ST_PROBE) ? ADDR_W'(mid_calc) : ADDR_W'(r_mid);

    stbs_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_low         <= n_low;
        r_high        <= n_high;
        r_mid         <= n_mid;
        r_found       <= n_found;
        r_match_index <= n_match_index;
        r_overflowed  <= n_overflowed;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_drop        = r_drop;
        n_key         = r_key;
        n_low         = r_low;
        n_high        = r_high;
        n_mid         = r_mid;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_found       = r_found;
        n_match_index = r_match_index;
        n_overflowed  = r_overflowed;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_command)
                        CMD_APPEND: begin
                            if (r_count < DEPTH_CNT) begin
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            n_key   = i_value;
                            n_low   = '0;
                            n_high  = $signed({1'b0, r_count}) - SRCH_W'(1);
                            n_state = ST_PROBE;
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_drop  = 1'b0;
                        end
                        default: begin
                            // unused code: drop it
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (r_low <= r_high) begin
                    n_mid   = mid_calc;
                    n_state = ST_CMP;
                end else if (out_free) begin
                    // range exhausted: report a miss
                    n_out_valid   = 1'b1;
                    n_found       = 1'b0;
                    n_match_index = '0;
                    n_overflowed  = r_drop;
                    n_state       = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (probe == r_key) begin
                    // hold here until the output register frees up
                    if (out_free) begin
                        n_out_valid   = 1'b1;
                        n_found       = 1'b1;
                        n_match_index = MATCH_W'(r_mid);
                        n_overflowed  = r_drop;
                        n_state       = ST_IDLE;
                    end
                end else if (probe < r_key) begin
                    n_low   = r_mid + SRCH_W'(1);
                    n_state = ST_PROBE;
                end else begin
                    n_high  = r_mid - SRCH_W'(1);
                    n_state = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;
    assign o_overflowed  = r_overflowed;

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_index == '0))
        else $error("miss reported with nonzero index");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count exceeds table depth");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> ((r_mid >= 0) && (r_mid < $signed({1'b0, r_count}))))
        else $error("probe outside entries in use");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_command == CMD_SEARCH)) |=> !o_in_ready)
        else $error("input ready right after a search was taken");

endmodule
